[rtl/core/fca_pkg.sv]
// Shared types and constants for the flyby closest-approach time block.
package fca_pkg;

	localparam int VAL_W      = 64;
	localparam int SIG_W      = 63;
	localparam int N_VEC      = 3;
	localparam int VEC_IW     = $clog2(N_VEC);
	localparam int MAX_STATES = 6;
	localparam int IDX_W      = 3;
	localparam int SC_W       = 3;
	localparam int COV_DEPTH  = MAX_STATES * MAX_STATES;
	localparam int COV_AW     = $clog2(COV_DEPTH);

	localparam logic [SC_W-1:0] STATE_COUNT_RESET = SC_W'(MAX_STATES);
	localparam logic [SC_W-1:0] STATE_COUNT_FULL  = SC_W'(MAX_STATES);
	localparam logic            REG_STATE_COUNT   = 1'b0;

	typedef enum logic [1:0] {
		MODE_LOAD_POS,
		MODE_LOAD_VEL,
		MODE_LOAD_COV,
		MODE_COMPUTE
	} fca_mode_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_S_SET,
		ST_S_NEXT,
		ST_D_SET,
		ST_D_NEXT,
		ST_MAC,
		ST_ABSD,
		ST_NUM,
		ST_TDIV_LD,
		ST_DIV,
		ST_TCA,
		ST_GV_SET,
		ST_GV_NEXT,
		ST_GR_SET,
		ST_GD_SET,
		ST_GR_NEXT,
		ST_Q_INIT,
		ST_W_RD,
		ST_W_SET,
		ST_W_NEXT,
		ST_WABS,
		ST_QG_SET,
		ST_QG_NEXT,
		ST_SIG_CHK,
		ST_SQRT,
		ST_SS_SET,
		ST_SDIV_LD,
		ST_SIG,
		ST_DONE
	} fca_state_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} fca_status_t;

	typedef struct packed {
		logic [VAL_W-1:0] tca_seconds;
		logic [SIG_W-1:0] tca_sigma;
		logic             degenerate;
	} fca_result_t;

endpackage

[rtl/core/fca_engine.sv]
// Sequenced compute engine: one wide adder shared by multiply, divide and square root passes.
module fca_engine (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            start,
	input  logic [fca_pkg::SC_W-1:0]                        state_count,
	input  logic [fca_pkg::N_VEC-1:0][fca_pkg::VAL_W-1:0]   pos,
	input  logic [fca_pkg::N_VEC-1:0][fca_pkg::VAL_W-1:0]   vel,
	output logic [fca_pkg::COV_AW-1:0]                      cov_addr,
	input  logic [fca_pkg::VAL_W-1:0]                       cov_data,
	output fca_pkg::fca_status_t                            status,
	input  logic                                            res_ready,
	output fca_pkg::fca_result_t                            res
);

	localparam int WIDE_W    = 576;
	localparam int S_W       = 128;
	localparam int D_W       = 130;
	localparam int G_W       = 193;
	localparam int ROOT_W    = 275;
	localparam int TCA_BITS  = 162;
	localparam int FRAC_SH   = 33;
	localparam int ROOT_FRAC = 96;
	localparam int SQ_SHIFT  = WIDE_W - 2 * ROOT_W + ROOT_FRAC;
	localparam int CNT_W     = 9;
	localparam int VW        = fca_pkg::VAL_W;
	localparam int SW        = fca_pkg::SIG_W;

	localparam logic [2:0] VEC_LAST = 3'(fca_pkg::N_VEC - 1);

	function automatic logic [VW-1:0] abs64(input logic [VW-1:0] x);
		return x[VW-1] ? (~x + VW'(1)) : x;
	endfunction

	fca_pkg::fca_state_t state_q, state_d, ret_q;

	logic [WIDE_W-1:0] acc_q, qsum_q, mc_q, mpl_q, rem_q, src_q, den_q;
	logic [S_W-1:0]    s_q;
	logic [D_W-1:0]    d_q;
	logic [G_W-1:0]    g_q [fca_pkg::MAX_STATES];
	logic [ROOT_W-1:0] root_q;
	logic [VW-1:0]     quo_q, tca_q;
	logic [SW-1:0]     sig_q;
	logic              msub_q, to_q_q, hi_q, deg_q;
	logic [2:0]        i_q, j_q;
	logic [CNT_W-1:0]  cnt_q;

	logic                        n6;
	logic [2:0]                  last_idx;
	logic [fca_pkg::VEC_IW-1:0]  vidx;
	logic [VW-1:0]               rv, vv;
	logic [2:0]                  g_idx;
	logic [G_W-1:0]              g_rd;
	logic [WIDE_W-1:0]           add_a, add_b, sum;
	logic                        add_sub;
	logic                        deg_in, d_pos, tca_sat;
	logic [VW-1:0]               tca_val;

	assign n6       = (state_count == fca_pkg::STATE_COUNT_FULL);
	assign last_idx = n6 ? 3'(fca_pkg::MAX_STATES - 1) : VEC_LAST;
	assign vidx     = i_q[fca_pkg::VEC_IW-1:0];
	assign rv       = pos[vidx];
	assign vv       = vel[vidx];
	assign g_idx    = (state_q == fca_pkg::ST_QG_SET) ? i_q : j_q;
	assign g_rd     = g_q[g_idx];
	assign deg_in   = (pos == '0) || (vel == '0);
	assign cov_addr = fca_pkg::COV_AW'(i_q) * fca_pkg::COV_AW'(fca_pkg::MAX_STATES)
		+ fca_pkg::COV_AW'(j_q);

	// shared adder
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q) inside
			fca_pkg::ST_MAC: begin
				add_a   = to_q_q ? qsum_q : acc_q;
				add_b   = mc_q;
				add_sub = msub_q;
			end
			fca_pkg::ST_ABSD, fca_pkg::ST_WABS: begin
				add_b   = acc_q;
				add_sub = 1'b1;
			end
			fca_pkg::ST_NUM: begin
				add_a = acc_q << FRAC_SH;
				add_b = WIDE_W'(s_q);
			end
			fca_pkg::ST_DIV: begin
				add_a   = {rem_q[WIDE_W-2:0], src_q[WIDE_W-1]};
				add_b   = den_q;
				add_sub = 1'b1;
			end
			fca_pkg::ST_SQRT: begin
				add_a   = {rem_q[WIDE_W-3:0], src_q[WIDE_W-1:WIDE_W-2]};
				add_b   = WIDE_W'({root_q, 2'b01});
				add_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign sum = add_a + (add_b ^ {WIDE_W{add_sub}}) + WIDE_W'(add_sub);

	// tca rounding result with saturation
	always_comb begin
		d_pos = !d_q[D_W-1] && (d_q != '0);
		if (d_pos) begin
			tca_sat = hi_q || (quo_q[VW-1] && (quo_q[VW-2:0] != '0));
			tca_val = tca_sat ? {1'b1, {(VW-1){1'b0}}} : (VW'(0) - quo_q);
		end else begin
			tca_sat = hi_q || quo_q[VW-1];
			tca_val = tca_sat ? {1'b0, {(VW-1){1'b1}}} : quo_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			fca_pkg::ST_IDLE:
				if (start) state_d = deg_in ? fca_pkg::ST_DONE : fca_pkg::ST_S_SET;
			fca_pkg::ST_S_SET, fca_pkg::ST_D_SET, fca_pkg::ST_GV_SET, fca_pkg::ST_GR_SET,
			fca_pkg::ST_GD_SET, fca_pkg::ST_W_SET, fca_pkg::ST_QG_SET, fca_pkg::ST_SS_SET:
				state_d = fca_pkg::ST_MAC;
			fca_pkg::ST_MAC:
				if (mpl_q == '0) state_d = ret_q;
			fca_pkg::ST_S_NEXT:
				state_d = (i_q == VEC_LAST) ? fca_pkg::ST_D_SET : fca_pkg::ST_S_SET;
			fca_pkg::ST_D_NEXT:
				state_d = (i_q == VEC_LAST) ? fca_pkg::ST_ABSD : fca_pkg::ST_D_SET;
			fca_pkg::ST_ABSD:
				state_d = fca_pkg::ST_NUM;
			fca_pkg::ST_NUM:
				state_d = fca_pkg::ST_TDIV_LD;
			fca_pkg::ST_TDIV_LD, fca_pkg::ST_SDIV_LD:
				state_d = fca_pkg::ST_DIV;
			fca_pkg::ST_DIV:
				if (cnt_q == '0) state_d = ret_q;
			fca_pkg::ST_TCA:
				state_d = fca_pkg::ST_GV_SET;
			fca_pkg::ST_GV_NEXT: begin
				if (n6) state_d = fca_pkg::ST_GR_SET;
				else if (i_q == VEC_LAST) state_d = fca_pkg::ST_Q_INIT;
				else state_d = fca_pkg::ST_GV_SET;
			end
			fca_pkg::ST_GR_NEXT:
				state_d = (i_q == VEC_LAST) ? fca_pkg::ST_Q_INIT : fca_pkg::ST_GV_SET;
			fca_pkg::ST_Q_INIT:
				state_d = fca_pkg::ST_W_RD;
			fca_pkg::ST_W_RD:
				state_d = fca_pkg::ST_W_SET;
			fca_pkg::ST_W_NEXT:
				state_d = (j_q == last_idx) ? fca_pkg::ST_WABS : fca_pkg::ST_W_RD;
			fca_pkg::ST_WABS:
				state_d = fca_pkg::ST_QG_SET;
			fca_pkg::ST_QG_NEXT:
				state_d = (i_q == last_idx) ? fca_pkg::ST_SIG_CHK : fca_pkg::ST_W_RD;
			fca_pkg::ST_SIG_CHK:
				state_d = qsum_q[WIDE_W-1] ? fca_pkg::ST_DONE : fca_pkg::ST_SQRT;
			fca_pkg::ST_SQRT:
				if (cnt_q == '0) state_d = fca_pkg::ST_SS_SET;
			fca_pkg::ST_SIG:
				state_d = fca_pkg::ST_DONE;
			fca_pkg::ST_DONE:
				if (res_ready) state_d = fca_pkg::ST_IDLE;
			default:
				state_d = fca_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fca_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer counters and return point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q <= fca_pkg::ST_IDLE;
			i_q   <= '0;
			j_q   <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				fca_pkg::ST_IDLE:    i_q <= '0;
				fca_pkg::ST_S_SET:   ret_q <= fca_pkg::ST_S_NEXT;
				fca_pkg::ST_D_SET:   ret_q <= fca_pkg::ST_D_NEXT;
				fca_pkg::ST_GV_SET:  ret_q <= fca_pkg::ST_GV_NEXT;
				fca_pkg::ST_GR_SET:  ret_q <= fca_pkg::ST_GD_SET;
				fca_pkg::ST_GD_SET:  ret_q <= fca_pkg::ST_GR_NEXT;
				fca_pkg::ST_W_SET:   ret_q <= fca_pkg::ST_W_NEXT;
				fca_pkg::ST_QG_SET:  ret_q <= fca_pkg::ST_QG_NEXT;
				fca_pkg::ST_SS_SET:  ret_q <= fca_pkg::ST_SDIV_LD;
				fca_pkg::ST_S_NEXT:  i_q <= (i_q == VEC_LAST) ? 3'd0 : i_q + 3'd1;
				fca_pkg::ST_D_NEXT:  if (i_q != VEC_LAST) i_q <= i_q + 3'd1;
				fca_pkg::ST_TDIV_LD: begin
					ret_q <= fca_pkg::ST_TCA;
					cnt_q <= CNT_W'(TCA_BITS - 1);
				end
				fca_pkg::ST_SDIV_LD: begin
					ret_q <= fca_pkg::ST_SIG;
					cnt_q <= CNT_W'(ROOT_W - 1);
				end
				fca_pkg::ST_SIG_CHK: cnt_q <= CNT_W'(ROOT_W - 1);
				fca_pkg::ST_DIV, fca_pkg::ST_SQRT:
					if (cnt_q != '0) cnt_q <= cnt_q - CNT_W'(1);
				fca_pkg::ST_TCA:     i_q <= '0;
				fca_pkg::ST_GV_NEXT: if (!n6) i_q <= i_q + 3'd1;
				fca_pkg::ST_GR_NEXT: i_q <= i_q + 3'd1;
				fca_pkg::ST_Q_INIT: begin
					i_q <= '0;
					j_q <= '0;
				end
				fca_pkg::ST_W_NEXT:  j_q <= (j_q == last_idx) ? 3'd0 : j_q + 3'd1;
				fca_pkg::ST_QG_NEXT: i_q <= i_q + 3'd1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fca_pkg::ST_IDLE: if (start) begin
				acc_q <= '0;
				deg_q <= deg_in;
				tca_q <= '0;
				sig_q <= '0;
			end
			fca_pkg::ST_S_SET: begin
				mc_q   <= WIDE_W'($signed(vv));
				mpl_q  <= WIDE_W'(abs64(vv));
				msub_q <= vv[VW-1];
				to_q_q <= 1'b0;
			end
			fca_pkg::ST_D_SET: begin
				mc_q   <= WIDE_W'($signed(rv));
				mpl_q  <= WIDE_W'(abs64(vv));
				msub_q <= vv[VW-1];
			end
			fca_pkg::ST_MAC: begin
				if (mpl_q[0]) begin
					if (to_q_q) qsum_q <= sum;
					else acc_q <= sum;
				end
				mc_q  <= mc_q << 1;
				mpl_q <= mpl_q >> 1;
			end
			fca_pkg::ST_S_NEXT: if (i_q == VEC_LAST) begin
				s_q   <= acc_q[S_W-1:0];
				acc_q <= '0;
			end
			fca_pkg::ST_D_NEXT: if (i_q == VEC_LAST) d_q <= acc_q[D_W-1:0];
			fca_pkg::ST_ABSD: if (acc_q[WIDE_W-1]) acc_q <= sum;
			fca_pkg::ST_NUM: acc_q <= sum;
			fca_pkg::ST_TDIV_LD: begin
				src_q <= {acc_q[TCA_BITS-1:0], {(WIDE_W-TCA_BITS){1'b0}}};
				den_q <= WIDE_W'({s_q, 1'b0});
				rem_q <= '0;
				quo_q <= '0;
				hi_q  <= 1'b0;
			end
			fca_pkg::ST_DIV: begin
				rem_q <= sum[WIDE_W-1] ? add_a : sum;
				quo_q <= {quo_q[VW-2:0], !sum[WIDE_W-1]};
				hi_q  <= hi_q | quo_q[VW-1];
				src_q <= src_q << 1;
			end
			fca_pkg::ST_TCA: begin
				tca_q <= tca_val;
				acc_q <= '0;
			end
			fca_pkg::ST_GV_SET: begin
				mc_q   <= WIDE_W'(s_q);
				mpl_q  <= WIDE_W'(abs64(vv));
				msub_q <= vv[VW-1];
				to_q_q <= 1'b0;
			end
			fca_pkg::ST_GV_NEXT: begin
				g_q[i_q] <= acc_q[G_W-1:0];
				acc_q    <= '0;
			end
			fca_pkg::ST_GR_SET: begin
				mc_q   <= WIDE_W'(s_q);
				mpl_q  <= WIDE_W'(abs64(rv));
				msub_q <= rv[VW-1];
			end
			fca_pkg::ST_GD_SET: begin
				mc_q   <= WIDE_W'($signed(d_q));
				mpl_q  <= WIDE_W'(abs64(vv));
				msub_q <= !vv[VW-1];
			end
			fca_pkg::ST_GR_NEXT: begin
				g_q[3'(i_q + 3'(fca_pkg::N_VEC))] <= acc_q[G_W-1:0];
				acc_q <= '0;
			end
			fca_pkg::ST_Q_INIT: begin
				acc_q  <= '0;
				qsum_q <= '0;
				to_q_q <= 1'b0;
			end
			fca_pkg::ST_W_SET: begin
				mc_q   <= WIDE_W'($signed(g_rd));
				mpl_q  <= WIDE_W'(abs64(cov_data));
				msub_q <= cov_data[VW-1];
				to_q_q <= 1'b0;
			end
			fca_pkg::ST_WABS: begin
				msub_q <= acc_q[WIDE_W-1];
				if (acc_q[WIDE_W-1]) acc_q <= sum;
			end
			fca_pkg::ST_QG_SET: begin
				mc_q   <= WIDE_W'($signed(g_rd));
				mpl_q  <= acc_q;
				to_q_q <= 1'b1;
			end
			fca_pkg::ST_QG_NEXT: begin
				acc_q  <= '0;
				to_q_q <= 1'b0;
			end
			fca_pkg::ST_SIG_CHK: begin
				if (qsum_q[WIDE_W-1]) begin
					sig_q <= '0;
				end else begin
					src_q  <= qsum_q << SQ_SHIFT;
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			fca_pkg::ST_SQRT: begin
				rem_q  <= sum[WIDE_W-1] ? add_a : sum;
				root_q <= {root_q[ROOT_W-2:0], !sum[WIDE_W-1]};
				src_q  <= src_q << 2;
			end
			fca_pkg::ST_SS_SET: begin
				acc_q  <= '0;
				mc_q   <= WIDE_W'(s_q);
				mpl_q  <= WIDE_W'(s_q);
				msub_q <= 1'b0;
				to_q_q <= 1'b0;
			end
			fca_pkg::ST_SDIV_LD: begin
				den_q <= acc_q;
				src_q <= {root_q, {(WIDE_W-ROOT_W){1'b0}}};
				rem_q <= '0;
				quo_q <= '0;
				hi_q  <= 1'b0;
			end
			fca_pkg::ST_SIG:
				sig_q <= (hi_q || quo_q[VW-1]) ? {SW{1'b1}} : quo_q[SW-1:0];
			default: begin
			end
		endcase
	end

	assign status.idle      = (state_q == fca_pkg::ST_IDLE);
	assign status.res_valid = (state_q == fca_pkg::ST_DONE);
	assign res.tca_seconds  = tca_q;
	assign res.tca_sigma    = sig_q;
	assign res.degenerate   = deg_q;

endmodule

[rtl/core/flyby_closest_approach_time.sv]
// Top level: load stores, configuration port, output register and the compute engine.
//
// Usage: the input channel (in_valid/in_ready) carries one transfer per item.
// Modes 0..2 write one position, velocity or covariance element and produce
// no result. Mode 3 starts a compute and yields one result
// transfer (tca_seconds, tca_sigma, degenerate) on the output channel.
// A compute runs bit-serially through one 576-bit adder: sums of products,
// a 162-step divide for tca, a 275-step square root and a 275-step divide for
// sigma. Each multiply pass handles one multiplier bit per step and stops once
// the remaining multiplier bits are zero. A negative variance skips the root
// and the sigma divide; a compute with a zero vector skips all of the work.
// in_ready is low for the whole compute and while its result waits to move
// into the output register. Loads are taken while an earlier result waits
// there. The output register holds its result until out_ready; a stalled
// receiver keeps the next result in the engine, with in_ready low. Reset
// clears control state and sets state_count to 6; the stores are undefined
// until loaded. state_count is written through the APB port at byte address 0.
module flyby_closest_approach_time (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic [fca_pkg::IDX_W-1:0]         row,
	input  logic [fca_pkg::IDX_W-1:0]         col,
	input  logic signed [fca_pkg::VAL_W-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [fca_pkg::VAL_W-1:0]  tca_seconds,
	output logic [fca_pkg::SIG_W-1:0]         tca_sigma,
	output logic                              degenerate
);

	logic [fca_pkg::SC_W-1:0]                      state_count_q;
	logic [fca_pkg::N_VEC-1:0][fca_pkg::VAL_W-1:0] pos_q, vel_q;
	logic [fca_pkg::VAL_W-1:0]                     cov_mem [fca_pkg::COV_DEPTH];
	logic [fca_pkg::VAL_W-1:0]                     cov_rd_q;
	logic [fca_pkg::COV_AW-1:0]                    cov_rd_addr, cov_wr_addr;
	logic                                          out_valid_q;
	fca_pkg::fca_status_t                          eng_status;
	fca_pkg::fca_result_t                          eng_res;
	logic                                          in_xfer, res_ready, res_load, cfg_wr;
	logic                                          vec_ok, cov_ok;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && (paddr[2] == fca_pkg::REG_STATE_COUNT);
	assign prdata  = (paddr[2] == fca_pkg::REG_STATE_COUNT) ? 32'(state_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q <= fca_pkg::STATE_COUNT_RESET;
		end else if (cfg_wr) begin
			state_count_q <= pwdata[fca_pkg::SC_W-1:0];
		end
	end

	assign in_ready    = eng_status.idle;
	assign in_xfer     = in_valid && in_ready;
	assign vec_ok      = (row < fca_pkg::IDX_W'(fca_pkg::N_VEC));
	assign cov_ok      = (row < fca_pkg::IDX_W'(fca_pkg::MAX_STATES))
		&& (col < fca_pkg::IDX_W'(fca_pkg::MAX_STATES));
	assign cov_wr_addr = fca_pkg::COV_AW'(row) * fca_pkg::COV_AW'(fca_pkg::MAX_STATES)
		+ fca_pkg::COV_AW'(col);

	always_ff @(posedge clk) begin
		if (in_xfer && vec_ok && (mode == fca_pkg::MODE_LOAD_POS))
			pos_q[row[fca_pkg::VEC_IW-1:0]] <= value;
		if (in_xfer && vec_ok && (mode == fca_pkg::MODE_LOAD_VEL))
			vel_q[row[fca_pkg::VEC_IW-1:0]] <= value;
		if (in_xfer && cov_ok && (mode == fca_pkg::MODE_LOAD_COV))
			cov_mem[cov_wr_addr] <= value;
		cov_rd_q <= cov_mem[cov_rd_addr];
	end

	fca_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_xfer && (mode == fca_pkg::MODE_COMPUTE)),
		.state_count (state_count_q),
		.pos         (pos_q),
		.vel         (vel_q),
		.cov_addr    (cov_rd_addr),
		.cov_data    (cov_rd_q),
		.status      (eng_status),
		.res_ready   (res_ready),
		.res         (eng_res)
	);

	assign res_ready = !out_valid_q || out_ready;
	assign res_load  = eng_status.res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			tca_seconds <= eng_res.tca_seconds;
			tca_sigma   <= eng_res.tca_sigma;
			degenerate  <= eng_res.degenerate;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[tb/sv/flyby_closest_approach_time_tb.sv]
// Testbench for the flyby closest-approach time block: table-driven and random checks.
`timescale 1ns / 100ps

module flyby_closest_approach_time_tb;
	import fca_pkg::*;

	typedef logic signed [639:0] wide_t;
	typedef logic [639:0]        uwide_t;

	typedef struct {
		fca_mode_t         m;
		logic [2:0]        r;
		logic [2:0]        c;
		logic signed [63:0] v;
		logic              typed;
		fca_result_t       res;
	} stim_t;

	localparam logic signed [63:0] V_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] V_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] V_ONE = 64'sh0000_0001_0000_0000;
	localparam fca_result_t DEGEN = '{tca_seconds: '0, tca_sigma: '0, degenerate: 1'b1};

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] mode;
	logic [IDX_W-1:0] row, col;
	logic signed [VAL_W-1:0] value, tca_seconds;
	logic [SIG_W-1:0] tca_sigma;
	logic degenerate;

	flyby_closest_approach_time u_top (.*);

	logic signed [63:0] pos_mem [3];
	logic signed [63:0] vel_mem [3];
	logic signed [63:0] cov_mem [36];
	logic [SC_W-1:0]    sc_model;

	fca_result_t approach_q[$];
	stim_t       table_q[$];
	int errors;
	int results_seen;
	bit calm;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (calm || p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic fca_result_t closest_approach();
		wide_t r[3], v[3], g[6], s, d, q, t;
		uwide_t num, den, quo, root, sq, trial;
		logic [63:0] lo;
		fca_result_t res;
		int n;
		res = '0;
		if ((pos_mem[0] | pos_mem[1] | pos_mem[2]) == 0 ||
		    (vel_mem[0] | vel_mem[1] | vel_mem[2]) == 0) begin
			res.degenerate = 1'b1;
			return res;
		end
		s = 0;
		d = 0;
		for (int i = 0; i < 3; i++) begin
			r[i] = pos_mem[i];
			v[i] = vel_mem[i];
			s = s + v[i] * v[i];
			d = d + r[i] * v[i];
		end
		t = (d < 0) ? -d : d;
		t = (t <<< 33) + s;
		num = t;
		den = s <<< 1;
		quo = num / den;
		lo = quo[63:0];
		if (d > 0)
			res.tca_seconds = (|quo[639:64] || lo > 64'h8000_0000_0000_0000) ?
				64'h8000_0000_0000_0000 : -lo;
		else
			res.tca_seconds = (|quo[639:64] || lo > 64'h7fff_ffff_ffff_ffff) ?
				64'h7fff_ffff_ffff_ffff : lo;
		n = (sc_model == STATE_COUNT_FULL) ? 6 : 3;
		for (int i = 0; i < 3; i++) begin
			g[i] = v[i] * s;
			g[3+i] = r[i] * s - d * v[i];
		end
		q = 0;
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				t = cov_mem[i*6+j];
				q = q + g[i] * t * g[j];
			end
		if (q >= 0) begin
			num = q <<< 96;
			root = '0;
			for (int k = 319; k >= 0; k--) begin
				trial = root;
				trial[k] = 1'b1;
				sq = trial * trial;
				if (sq <= num) root = trial;
			end
			t = s * s;
			den = t;
			quo = root / den;
			lo = quo[63:0];
			if (|quo[639:64] || lo > 64'h7fff_ffff_ffff_ffff) lo = 64'h7fff_ffff_ffff_ffff;
			res.tca_sigma = lo[62:0];
		end
		return res;
	endfunction

	// apply one accepted transfer to the shadow stores, or queue a compute's expected result
	task automatic track(input stim_t it);
		fca_result_t p;
		case (it.m)
			MODE_LOAD_POS: if (it.r < 3) pos_mem[it.r] = it.v;
			MODE_LOAD_VEL: if (it.r < 3) vel_mem[it.r] = it.v;
			MODE_LOAD_COV: if (it.r < 6 && it.c < 6) cov_mem[it.r*6+it.c] = it.v;
			default: begin
				p = closest_approach();
				approach_q.push_back(it.typed ? it.res : p);
			end
		endcase
	endtask

	task automatic push(input stim_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		mode <= it.m;
		row <= it.r;
		col <= it.c;
		value <= it.v;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		track(it);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (approach_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_state_count(input logic [2:0] sc);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(REG_STATE_COUNT) << 2;
		pwdata <= ($urandom & 32'hffff_fff8) | 32'(sc);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sc_model = sc;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic stim_t mk(fca_mode_t m, int r, int c, logic signed [63:0] v,
		logic typed = 1'b0, fca_result_t res = '0);
		stim_t it;
		it.m = m;
		it.r = 3'(r);
		it.c = 3'(c);
		it.v = v;
		it.typed = typed;
		it.res = res;
		return it;
	endfunction

	function automatic logic signed [63:0] rand_value();
		logic signed [63:0] x;
		int p;
		x = {$urandom, $urandom};
		p = $urandom_range(0, 99);
		if (p < 30) return x;
		if (p < 85) return x >>> $urandom_range(8, 40);
		case ($urandom_range(0, 4))
			0: return V_MAX;
			1: return V_MIN;
			2: return 64'sd0;
			3: return -64'sd1;
			default: return V_ONE;
		endcase
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 99) < 30) begin
			out_ready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		fca_result_t w;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (approach_q.size() == 0) begin
				report("unexpected result", tca_seconds, '0);
			end else begin
				w = approach_q.pop_front();
				if (tca_seconds !== w.tca_seconds) report("tca_seconds", tca_seconds, w.tca_seconds);
				if (tca_sigma !== w.tca_sigma) report("tca_sigma", 64'(tca_sigma), 64'(w.tca_sigma));
				if (degenerate !== w.degenerate) report("degenerate", 64'(degenerate), 64'(w.degenerate));
			end
		end
	end

	initial begin
		logic [2:0] phase_sc [4] = '{3'd3, 3'd6, 3'd5, 3'd4};
		stim_t it;
		int items, start_res, p;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		mode = '0;
		row = '0;
		col = '0;
		value = '0;
		out_ready = 1'b0;
		errors = 0;
		results_seen = 0;
		calm = 1'b0;
		stall_left = 0;
		sc_model = STATE_COUNT_RESET;
		foreach (pos_mem[i]) pos_mem[i] = '0;
		foreach (vel_mem[i]) vel_mem[i] = '0;
		foreach (cov_mem[i]) cov_mem[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// covariance fully written before any compute can read it
		for (int i = 0; i < 36; i++) push(mk(MODE_LOAD_COV, i / 6, i % 6, rand_value()));

		table_q.push_back(mk(MODE_LOAD_POS, 0, 0, 64'sd0));
		table_q.push_back(mk(MODE_LOAD_POS, 1, 0, 64'sd0));
		table_q.push_back(mk(MODE_LOAD_POS, 2, 0, 64'sd0));
		table_q.push_back(mk(MODE_LOAD_VEL, 0, 0, V_ONE));
		table_q.push_back(mk(MODE_LOAD_VEL, 1, 0, 64'sd0));
		table_q.push_back(mk(MODE_LOAD_VEL, 2, 0, 64'sd0));
		table_q.push_back(mk(MODE_COMPUTE, 0, 0, 64'sd0, 1'b1, DEGEN));
		table_q.push_back(mk(MODE_LOAD_POS, 3, 0, V_ONE));
		table_q.push_back(mk(MODE_LOAD_POS, 7, 7, V_MAX));
		table_q.push_back(mk(MODE_LOAD_VEL, 5, 0, V_ONE));
		table_q.push_back(mk(MODE_LOAD_COV, 6, 0, V_MIN));
		table_q.push_back(mk(MODE_LOAD_COV, 2, 7, V_MIN));
		table_q.push_back(mk(MODE_COMPUTE, 7, 7, -64'sd1, 1'b1, DEGEN));
		table_q.push_back(mk(MODE_LOAD_POS, 0, 0, V_MAX));
		table_q.push_back(mk(MODE_COMPUTE, 0, 0, 64'sd0));
		table_q.push_back(mk(MODE_LOAD_POS, 1, 0, V_MIN));
		table_q.push_back(mk(MODE_LOAD_VEL, 2, 0, V_MIN));
		table_q.push_back(mk(MODE_COMPUTE, 0, 0, 64'sd0));
		table_q.push_back(mk(MODE_LOAD_VEL, 0, 0, 64'sd0));
		table_q.push_back(mk(MODE_LOAD_VEL, 2, 0, 64'sd0));
		table_q.push_back(mk(MODE_COMPUTE, 0, 0, 64'sd0, 1'b1, DEGEN));
		table_q.push_back(mk(MODE_LOAD_VEL, 1, 0, 64'sd1));
		table_q.push_back(mk(MODE_COMPUTE, 0, 0, 64'sd0));
		table_q.push_back(mk(MODE_LOAD_COV, 0, 0, V_MIN));
		table_q.push_back(mk(MODE_LOAD_COV, 5, 5, V_MAX));
		table_q.push_back(mk(MODE_COMPUTE, 0, 0, 64'sd0));
		foreach (table_q[i]) push(table_q[i]);
		drain();

		foreach (phase_sc[ph]) begin
			write_state_count(phase_sc[ph]);
			calm = (ph == 1);
			items = 0;
			start_res = results_seen;
			while (items < 300 || results_seen - start_res < 12) begin
				p = $urandom_range(0, 99);
				if (p < 4) begin
					it = mk(fca_mode_t'($urandom_range(0, 2)), $urandom_range(6, 7),
						$urandom_range(0, 7), rand_value());
					push(it);
					continue;
				end
				if (p < 12) it = mk(MODE_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
					rand_value());
				else if (p < 30) it = mk(MODE_LOAD_POS, $urandom_range(0, 2),
					$urandom_range(0, 7), rand_value());
				else if (p < 48) it = mk(MODE_LOAD_VEL, $urandom_range(0, 2),
					$urandom_range(0, 7), rand_value());
				else it = mk(MODE_LOAD_COV, $urandom_range(0, 5), $urandom_range(0, 5),
					rand_value());
				push(it);
				items++;
				// let the output side empty completely once per phase
				if (items == 150) begin
					@(negedge clk);
					in_valid <= 1'b0;
					while (approach_q.size() != 0) @(posedge clk);
				end
			end
			drain();
		end
		write_state_count(STATE_COUNT_FULL);
		push(mk(MODE_COMPUTE, 0, 0, 64'sd0));
		drain();

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/fca_pkg.sv
rtl/core/fca_engine.sv
rtl/core/flyby_closest_approach_time.sv
tb/sv/flyby_closest_approach_time_tb.sv
